// ===== hdl/sba_pkg.sv =====
`default_nettype none

package sba_pkg;

	localparam int MAP_BYTES_DEF = 256;
	localparam logic [10:0] SECTOR_COUNT_RST = 11'd720;

	typedef enum logic [2:0] {
		KIND_LOAD   = 3'd0,
		KIND_READ   = 3'd1,
		KIND_QUERY  = 3'd2,
		KIND_USED   = 3'd3,
		KIND_FREE   = 3'd4,
		KIND_ALLOC  = 3'd5,
		KIND_COUNT  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BYTE,
		ST_BYTE2,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [10:0] sector_out;
		logic        is_used;
		logic [7:0]  byte_out;
		logic [11:0] free_count;
		logic        status;
	} result_t;

	// The most significant bit of a bitmap byte is its lowest sector.
	function automatic logic [7:0] bit_mask(input logic [2:0] k);
		return 8'h80 >> k;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sector_bitmap_allocator.sv =====
// Free-space bitmap allocator, first fit. A set bit in the bitmap means the
// sector is free; sector s sits in byte s/8, the byte's MSB being its lowest
// sector.
// Requests arrive on req_valid/req_stall with kind, sector, range_end,
// byte_index and byte_data; every request gives exactly one item on
// rsp_valid/rsp_stall. Fields a kind does not produce come back as zero.
// cfg_we writes sector_count, the upper bound of the allocation search; the
// user must see that it is written only while the block is idle, as the
// block itself does not enforce this. An unused kind or an empty count
// range goes from idle straight to ST_OUT; load passes through ST_BYTE, and
// read, query and mark through ST_BYTE and ST_BYTE2, before ST_OUT.
// Allocate and count stream the bitmap through the single read port of the
// map memory in ST_SCAN, one byte per cycle. One request is in work at a
// time, so a new item is accepted once the previous result has entered the
// output register, even while that result is still held there.
// After reset the map memory is cleared one byte per cycle, with req_stall
// high until the last byte is written; every sector then reads used.
// When the receiver stalls, the result stays in the output register and
// the next finished result waits in its state until the register frees.

`default_nettype none

module sector_bitmap_allocator #(
	parameter int MAP_BYTES = sba_pkg::MAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [10:0] sector,
	input  wire logic [11:0] range_end,
	input  wire logic [7:0]  byte_index,
	input  wire logic [7:0]  byte_data,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [10:0]      sector_out,
	output logic             is_used,
	output logic [7:0]       byte_out,
	output logic [11:0]      free_count,
	output logic             status
);

	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

	function automatic logic [AW-1:0] addr_of(input logic [7:0] b);
		logic [31:0] w;
		w = 32'(b);
		return w[AW-1:0];
	endfunction

	function automatic logic in_map(input logic [7:0] b);
		return 32'(b) < 32'(MAP_BYTES);
	endfunction

	sba_pkg::state_t state_q, state_d;

	logic [10:0] sector_count_q;
	logic [AW-1:0] clr_ptr_q;

	logic [7:0] mem [MAP_BYTES];
	logic [7:0] rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata;

	// Latched request.
	logic [2:0]    kind_q;
	logic [10:0]   sec_q;
	logic [AW-1:0] addr_q;
	logic          ok_q;
	logic [7:0]    data_q;
	logic [11:0]   lo_q, hi_q;
	logic [7:0]    last_q;
	logic [11:0]   cnt_q;

	// Scan read pipeline.
	logic [8:0] rd_ptr_q;
	logic       dval_s1;
	logic [7:0] dbyte_s1;
	logic       issue;

	sba_pkg::result_t res_q, res_d, rsp_q;
	logic res_load;
	logic rsp_valid_q;
	logic accept;
	logic rsp_free;

	// Scan datapath.
	logic [7:0]  scan_d, range_m, hits;
	logic [3:0]  pop;
	logic [2:0]  pos;
	logic [11:0] s_k;

	// Current-request helpers.
	logic [7:0] bm;
	logic [7:0] cur_d;
	logic [11:0] count_last;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != sba_pkg::ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign issue     = (rd_ptr_q <= {1'b0, last_q});
	assign bm        = sba_pkg::bit_mask(sec_q[2:0]);
	assign cur_d     = ok_q ? rdata_q : 8'h00;
	assign count_last = range_end - 12'd1;

	always_comb begin
		scan_d = in_map(dbyte_s1) ? rdata_q : 8'h00;
		for (int k = 0; k < 8; k++) begin
			s_k = {1'b0, dbyte_s1, 3'(k)};
			range_m[7 - k] = (s_k >= lo_q) && (s_k < hi_q);
		end
		hits = scan_d & range_m;
		pop = '0;
		pos = '0;
		for (int k = 7; k >= 0; k--) begin
			pop = pop + 4'(hits[k]);
			if (hits[7 - k]) begin
				pos = 3'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		res_load  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			sba_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q;
				if (clr_ptr_q == LAST_ADDR) begin
					state_d = sba_pkg::ST_IDLE;
				end
			end
			sba_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind) inside
						sba_pkg::KIND_LOAD, sba_pkg::KIND_READ, sba_pkg::KIND_QUERY,
						sba_pkg::KIND_USED, sba_pkg::KIND_FREE: begin
							state_d = sba_pkg::ST_BYTE;
						end
						sba_pkg::KIND_ALLOC: begin
							state_d = sba_pkg::ST_SCAN;
						end
						sba_pkg::KIND_COUNT: begin
							if (range_end <= {1'b0, sector}) begin
								res_load = 1'b1;
								state_d  = sba_pkg::ST_OUT;
							end else begin
								state_d = sba_pkg::ST_SCAN;
							end
						end
						default: begin
							res_load = 1'b1;
							state_d  = sba_pkg::ST_OUT;
						end
					endcase
				end
			end
			sba_pkg::ST_BYTE: begin
				if (kind_q == sba_pkg::KIND_LOAD) begin
					mem_we    = ok_q;
					mem_wdata = data_q;
					res_load  = 1'b1;
					state_d   = sba_pkg::ST_OUT;
				end else begin
					state_d = sba_pkg::ST_BYTE2;
				end
			end
			sba_pkg::ST_BYTE2: begin
				res_load = 1'b1;
				state_d  = sba_pkg::ST_OUT;
				case (kind_q)
					sba_pkg::KIND_READ: begin
						res_d.byte_out = cur_d;
					end
					sba_pkg::KIND_QUERY: begin
						res_d.is_used = ((cur_d & bm) == 8'h00);
					end
					sba_pkg::KIND_USED: begin
						mem_we    = ok_q;
						mem_wdata = rdata_q & ~bm;
					end
					sba_pkg::KIND_FREE: begin
						mem_we    = ok_q;
						mem_wdata = rdata_q | bm;
					end
					default: begin
					end
				endcase
			end
			sba_pkg::ST_SCAN: begin
				mem_raddr = addr_of(rd_ptr_q[7:0]);
				if (dval_s1) begin
					if (kind_q == sba_pkg::KIND_ALLOC) begin
						if (hits != 8'h00) begin
							// First free sector: claim it in place.
							mem_we           = 1'b1;
							mem_waddr        = addr_of(dbyte_s1);
							mem_wdata        = rdata_q & ~sba_pkg::bit_mask(pos);
							res_load         = 1'b1;
							res_d.sector_out = {dbyte_s1, pos};
							state_d          = sba_pkg::ST_OUT;
						end else if (dbyte_s1 == last_q) begin
							res_load     = 1'b1;
							res_d.status = 1'b1;
							state_d      = sba_pkg::ST_OUT;
						end
					end else if (dbyte_s1 == last_q) begin
						res_load         = 1'b1;
						res_d.free_count = cnt_q + 12'(pop);
						state_d          = sba_pkg::ST_OUT;
					end
				end
			end
			sba_pkg::ST_OUT: begin
				if (rsp_free) begin
					state_d = sba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_count_q <= sba_pkg::SECTOR_COUNT_RST;
			clr_ptr_q      <= '0;
			dval_s1        <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				sector_count_q <= cfg_wdata;
			end
			if (state_q == sba_pkg::ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
			if (state_q == sba_pkg::ST_SCAN && !accept) begin
				dval_s1 <= issue;
			end else begin
				dval_s1 <= 1'b0;
			end
			if (state_q == sba_pkg::ST_OUT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			sec_q    <= sector;
			data_q   <= byte_data;
			cnt_q    <= '0;
			if (kind == sba_pkg::KIND_LOAD || kind == sba_pkg::KIND_READ) begin
				addr_q <= addr_of(byte_index);
				ok_q   <= in_map(byte_index);
			end else begin
				addr_q <= addr_of(sector[10:3]);
				ok_q   <= in_map(sector[10:3]);
			end
			if (kind == sba_pkg::KIND_ALLOC) begin
				lo_q     <= 12'd1;
				hi_q     <= {1'b0, sector_count_q} + 12'd1;
				last_q   <= sector_count_q[10:3];
				rd_ptr_q <= '0;
			end else begin
				lo_q     <= {1'b0, sector};
				hi_q     <= range_end;
				// A range that ends past the last sector stops at the last byte.
				last_q   <= count_last[11] ? 8'hFF : count_last[10:3];
				rd_ptr_q <= {1'b0, sector[10:3]};
			end
		end else if (state_q == sba_pkg::ST_SCAN) begin
			dbyte_s1 <= rd_ptr_q[7:0];
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 9'd1;
			end
			if (dval_s1) begin
				cnt_q <= cnt_q + 12'(pop);
			end
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == sba_pkg::ST_OUT && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign sector_out = rsp_q.sector_out;
	assign is_used    = rsp_q.is_used;
	assign byte_out   = rsp_q.byte_out;
	assign free_count = rsp_q.free_count;
	assign status     = rsp_q.status;

	// The only write a scan makes is the claim of an allocated sector.
	a_scan_write_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_SCAN && mem_we) |-> (kind_q == sba_pkg::KIND_ALLOC))
		else $error("scan wrote the map outside an allocation");

	// A result leaving its holding state shows up on the output next cycle.
	a_out_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_OUT && rsp_free) |=> rsp_valid)
		else $error("finished item did not reach the output register");

	// Bytes in the read pipeline never run past the last byte of the range.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_SCAN && dval_s1) |-> (dbyte_s1 <= last_q))
		else $error("scan passed the end of its range");

	// A free count cannot exceed the width of the range it covers.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sba_pkg::ST_SCAN && res_load && kind_q == sba_pkg::KIND_COUNT)
		|-> (res_d.free_count <= hi_q - lo_q))
		else $error("free count larger than its range");

endmodule

`default_nettype wire

// ===== bench/sector_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps

module sector_bitmap_allocator_tb;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;
	localparam int ITEMS_PER_PHASE = 188;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [2:0] KIND_NONE = 3'd7;

	localparam sba_pkg::result_t R_ZERO = '0;
	localparam sba_pkg::result_t R_FULL = '{11'd0, 1'b0, 8'd0, 12'd0, 1'b1};
	localparam sba_pkg::result_t R_USED = '{11'd0, 1'b1, 8'd0, 12'd0, 1'b0};
	localparam sba_pkg::result_t R_FF = '{11'd0, 1'b0, 8'hFF, 12'd0, 1'b0};
	localparam sba_pkg::result_t R_01 = '{11'd0, 1'b0, 8'h01, 12'd0, 1'b0};
	localparam sba_pkg::result_t R_SECTOR1 = '{11'd1, 1'b0, 8'd0, 12'd0, 1'b0};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] sector;
		logic [11:0] range_end;
		logic [7:0]  byte_index;
		logic [7:0]  byte_data;
	} request_t;

	typedef struct packed {
		logic             wr_cfg;
		logic [10:0]      cfg_val;
		request_t         req;
		logic             typed;
		sba_pkg::result_t want;
	} plan_row_t;

	// Fields: register write, register value, item, expectation typed in, expectation.
	localparam plan_row_t PLAN [29] = '{
		'{1'b1, 11'd720, '0, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_READ, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_QUERY, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_USED},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_FULL},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd0, 12'd2048, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_LOAD, 11'd0, 12'd0, 8'd0, 8'hFF}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_READ, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_FF},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_SECTOR1},
		'{1'b0, 11'd0, '{sba_pkg::KIND_QUERY, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_QUERY, 11'd1, 12'd0, 8'd0, 8'd0}, 1'b1, R_USED},
		'{1'b0, 11'd0, '{sba_pkg::KIND_LOAD, 11'd0, 12'd0, 8'd255, 8'h01}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_READ, 11'd0, 12'd0, 8'd255, 8'd0}, 1'b1, R_01},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd0, 12'd2048, 8'd0, 8'd0}, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd2047, 12'd4095, 8'd0, 8'd0}, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd100, 12'd5, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd8, 12'd8, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_USED, 11'd2047, 12'd0, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_QUERY, 11'd2047, 12'd0, 8'd0, 8'd0}, 1'b1, R_USED},
		'{1'b0, 11'd0, '{sba_pkg::KIND_FREE, 11'd720, 12'd0, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{KIND_NONE, 11'd2047, 12'd4095, 8'd255, 8'hFF}, 1'b1, R_ZERO},
		'{1'b1, 11'd0, '0, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_FULL},
		'{1'b1, 11'd2047, '0, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_COUNT, 11'd0, 12'd2048, 8'd0, 8'd0}, 1'b0, R_ZERO},
		'{1'b1, 11'd1, '0, 1'b0, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_FULL},
		'{1'b0, 11'd0, '{sba_pkg::KIND_FREE, 11'd1, 12'd0, 8'd0, 8'd0}, 1'b1, R_ZERO},
		'{1'b0, 11'd0, '{sba_pkg::KIND_ALLOC, 11'd0, 12'd0, 8'd0, 8'd0}, 1'b1, R_SECTOR1}
	};

	localparam idle_mode_t PHASE_MODE [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  kind = '0;
	logic [10:0] sector = '0;
	logic [11:0] range_end = '0;
	logic [7:0]  byte_index = '0;
	logic [7:0]  byte_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [10:0] sector_out;
	logic        is_used;
	logic [7:0]  byte_out;
	logic [11:0] free_count;
	logic        status;

	logic [7:0]  shadow_map [sba_pkg::MAP_BYTES_DEF] = '{default: '0};
	logic [10:0] shadow_count = sba_pkg::SECTOR_COUNT_RST;
	sba_pkg::result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_alloc = 0;
	int n_full = 0;
	int n_count = 0;

	sector_bitmap_allocator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.sector     (sector),
		.range_end  (range_end),
		.byte_index (byte_index),
		.byte_data  (byte_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sector_out (sector_out),
		.is_used    (is_used),
		.byte_out   (byte_out),
		.free_count (free_count),
		.status     (status)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Sectors past the end of the map only come up in count ranges and read as used.
	function automatic bit sector_free(int s);
		if (s >= 8 * sba_pkg::MAP_BYTES_DEF)
			return 1'b0;
		return shadow_map[s >> 3][7 - (s & 7)];
	endfunction

	task automatic predict_bitmap_result(input request_t r, output sba_pkg::result_t res);
		int s;
		res = '0;
		case (r.kind)
		sba_pkg::KIND_LOAD: shadow_map[r.byte_index] = r.byte_data;
		sba_pkg::KIND_READ: res.byte_out = shadow_map[r.byte_index];
		sba_pkg::KIND_QUERY: res.is_used = !sector_free(r.sector);
		sba_pkg::KIND_USED: shadow_map[r.sector[10:3]][7 - r.sector[2:0]] = 1'b0;
		sba_pkg::KIND_FREE: shadow_map[r.sector[10:3]][7 - r.sector[2:0]] = 1'b1;
		sba_pkg::KIND_ALLOC: begin
			n_alloc++;
			res.status = 1'b1;
			for (s = 1; s <= shadow_count; s++) begin
				if (sector_free(s)) begin
					shadow_map[s >> 3][7 - (s & 7)] = 1'b0;
					res.sector_out = s[10:0];
					res.status = 1'b0;
					break;
				end
			end
			if (res.status)
				n_full++;
		end
		sba_pkg::KIND_COUNT: begin
			n_count++;
			for (s = r.sector; s < r.range_end; s++) begin
				if (sector_free(s))
					res.free_count = res.free_count + 12'd1;
			end
		end
		default: ;
		endcase
	endtask

	function automatic request_t random_request();
		request_t r;
		int roll;
		int hi;
		int pick;
		roll = $urandom_range(0, 99);
		hi = (shadow_count < 15) ? 15 : int'(shadow_count);
		// Most sectors and bytes fall inside the allocation window so that loads,
		// marks and allocations act on the same part of the map.
		r.sector = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, hi))
			: 11'($urandom_range(0, 2047));
		r.byte_index = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, hi >> 3))
			: 8'($urandom_range(0, 255));
		r.range_end = 12'($urandom_range(0, 4095));
		pick = $urandom_range(0, 4);
		r.byte_data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
		if (roll < 14)
			r.kind = sba_pkg::KIND_LOAD;
		else if (roll < 24)
			r.kind = sba_pkg::KIND_READ;
		else if (roll < 36)
			r.kind = sba_pkg::KIND_QUERY;
		else if (roll < 46)
			r.kind = sba_pkg::KIND_USED;
		else if (roll < 60)
			r.kind = sba_pkg::KIND_FREE;
		else if (roll < 80)
			r.kind = sba_pkg::KIND_ALLOC;
		else if (roll < 96) begin
			r.kind = sba_pkg::KIND_COUNT;
			pick = $urandom_range(0, 19);
			if (pick < 12)
				r.range_end = 12'(r.sector + $urandom_range(0, 80));
			else if (pick < 17)
				r.range_end = 12'($urandom_range(0, 2048));
		end else
			r.kind = KIND_NONE;
		return r;
	endfunction

	task automatic send_request(input request_t r, input bit typed,
		input sba_pkg::result_t want);
		sba_pkg::result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= r.kind;
		sector <= r.sector;
		range_end <= r.range_end;
		byte_index <= r.byte_index;
		byte_data <= r.byte_data;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		predict_bitmap_result(r, res);
		pending_results.push_back(typed ? want : res);
		n_requests++;
	endtask

	task automatic set_sector_count(input logic [10:0] value);
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_count = value;
	endtask

	task automatic note_mismatch(input string what, input sba_pkg::result_t want,
		input sba_pkg::result_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s: expected sector %0d used %0d byte %h count %0d status %0d,",
				$time, what, want.sector_out, want.is_used, want.byte_out, want.free_count,
				want.status, " got sector %0d used %0d byte %h count %0d status %0d",
				got.sector_out, got.is_used, got.byte_out, got.free_count, got.status);
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		sba_pkg::result_t got;
		sba_pkg::result_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			got = '{sector_out, is_used, byte_out, free_count, status};
			n_results++;
			if (pending_results.size() == 0)
				note_mismatch("result item with no request waiting", R_ZERO, got);
			else begin
				want = pending_results.pop_front();
				if (got.sector_out !== want.sector_out || got.is_used !== want.is_used ||
						got.byte_out !== want.byte_out || got.free_count !== want.free_count ||
						got.status !== want.status)
					note_mismatch("result item differs", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still waiting", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [10:0] limit;
		idle_mode_t mode;
		wait (arst_n === 1'b1);

		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].wr_cfg)
				set_sector_count(PLAN[i].cfg_val);
			else
				send_request(PLAN[i].req, PLAN[i].typed, PLAN[i].want);
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: limit = 11'd2047;
			1: limit = sba_pkg::SECTOR_COUNT_RST;
			2: limit = 11'($urandom_range(1, 2046));
			default: limit = 11'($urandom_range(8, 200));
			endcase
			set_sector_count(limit);
			mode = PHASE_MODE[p];
			send_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 13 : 0;
			recv_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 13 : 0;
			// The receiver holds off long enough for the block to fill and stall
			// the sender, which keeps offering items meanwhile.
			if (p == 0)
				hold_cycles = HOLD_OFF_CYCLES;
			repeat (ITEMS_PER_PHASE)
				send_request(random_request(), 1'b0, R_ZERO);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests and checked %0d results: %0d allocations, %0d on a full map,",
			n_requests, n_results, n_alloc, n_full, " %0d range counts, %0d mismatches.",
			n_count, fail_count);
		$display("Sector limits 0, 1, 720, 2047 and random; no idling, sender gaps, receiver %s",
			"stalls, both, and one long receiver hold-off.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
